/* rtl/core/tabq_pkg.sv */
// Shared definitions for the three-axis biquad low-pass filter.
// Holds default widths, the axis count and the configuration register indexes.
// No dependencies; the top level in rtl/core refers to it by scoped names.
package tabq_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int AXIS_COUNT         = 3;
    localparam int CFG_IDX_WIDTH      = 3;

    // Configuration register indexes, in register-map order.
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_FILTER_MODE = 3'd0,
        CFG_COEF_B0     = 3'd1,
        CFG_COEF_B1     = 3'd2,
        CFG_COEF_B2     = 3'd3,
        CFG_COEF_A1     = 3'd4,
        CFG_COEF_A2     = 3'd5
    } t_cfg_idx;

endpackage

/* rtl/core/tabq_lane.sv */
// One axis of the filter: a direct-form-I biquad with its own sample history.
// Computes, rounds and saturates a result in the cycle a transaction is accepted.
// Depends on nothing but its parameters; instantiated once per axis by the top level.
module tabq_lane #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic                              i_mode,
    input  logic signed [COEF_FRAC_BITS+2:0]  i_coef_b0,
    input  logic signed [COEF_FRAC_BITS+2:0]  i_coef_b1,
    input  logic signed [COEF_FRAC_BITS+2:0]  i_coef_b2,
    input  logic signed [COEF_FRAC_BITS+2:0]  i_coef_a1,
    input  logic signed [COEF_FRAC_BITS+2:0]  i_coef_a2,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    output logic signed [SAMPLE_WIDTH-1:0]    o_result
);

    localparam int CW = COEF_FRAC_BITS + 3;
    localparam int PW = CW + SAMPLE_WIDTH;
    localparam int AW = PW + 3;
    localparam int QW = AW - COEF_FRAC_BITS;
    localparam logic signed [AW-1:0] HALF =
        {{(AW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] r_x1, r_x2, r_y1, r_y2;
    logic signed [PW-1:0]           w_p_b0, w_p_b1, w_p_b2, w_p_a1, w_p_a2;
    logic signed [AW-1:0]           w_acc, w_rnd;
    logic signed [QW-1:0]           w_q;
    logic signed [SAMPLE_WIDTH-1:0] w_sat;
    logic                           w_fits;

    assign w_p_b0 = i_coef_b0 * i_sample;
    assign w_p_b1 = i_coef_b1 * r_x1;
    assign w_p_b2 = i_coef_b2 * r_x2;
    assign w_p_a1 = i_coef_a1 * r_y1;
    assign w_p_a2 = i_coef_a2 * r_y2;

    assign w_acc = w_p_b0 + w_p_b1 + w_p_b2 - w_p_a1 - w_p_a2;

    // Round half up, then floor by an arithmetic shift.
    assign w_rnd = w_acc + HALF;
    assign w_q   = w_rnd[AW-1:COEF_FRAC_BITS];

    // The quotient fits when all bits above the sample's sign bit copy it.
    assign w_fits = (w_q[QW-1:SAMPLE_WIDTH-1] == {(QW-SAMPLE_WIDTH+1){1'b0}}) ||
                    (w_q[QW-1:SAMPLE_WIDTH-1] == {(QW-SAMPLE_WIDTH+1){1'b1}});

    always_comb begin
        if (w_fits) begin
            w_sat = w_q[SAMPLE_WIDTH-1:0];
        end else if (w_q[QW-1]) begin
            w_sat = SAT_MIN;
        end else begin
            w_sat = SAT_MAX;
        end
    end

    assign o_result = i_mode ? w_sat : i_sample;

    // History advances only on filtered transactions; bypass leaves it alone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_accept && i_mode) begin
            r_x2 <= r_x1;
            r_x1 <= i_sample;
            r_y2 <= r_y1;
            r_y1 <= w_sat;
        end
    end

endmodule

/* rtl/core/tabq_merge.sv */
// Merging stage: gathers the lane results of one transaction into a two-entry buffer.
// Decouples the output handshake so a new transaction can enter while one waits.
// Depends on nothing but its data-width parameter.
module tabq_merge #(
    parameter int DATA_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [DATA_WIDTH-1:0] i_data,
    input  logic                  i_stall,
    output logic                  o_full,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_mem [2];
    logic                  r_wp, r_rp;
    logic [1:0]            r_cnt;
    logic                  w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign w_pop   = o_valid && !i_stall;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

/* rtl/core/three_axis_biquad_lowpass.sv */
// Three-axis biquad low-pass filter. Latency: a result is offered in the cycle after its
// transaction is accepted, unless an earlier result is still waiting ahead of it.
// Throughput: one transaction per cycle while the output buffer is not full, set by each lane's
// combinational multiply-accumulate, round and saturate loop that feeds the next sample.
// Reset is synchronous and active low: it clears the filter history, selects bypass,
// loads unity pass-through coefficients and empties the output buffer.
module three_axis_biquad_lowpass #(
    parameter int SAMPLE_WIDTH   = tabq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = tabq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [tabq_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [COEF_FRAC_BITS+2:0]          i_cfg_data,
    // Sample input channel.
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_gyro_x,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_gyro_y,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_gyro_z,
    // Filtered output channel.
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]     o_filt_x,
    output logic signed [SAMPLE_WIDTH-1:0]     o_filt_y,
    output logic signed [SAMPLE_WIDTH-1:0]     o_filt_z
);

    localparam int CW   = COEF_FRAC_BITS + 3;
    localparam int AXES = tabq_pkg::AXIS_COUNT;
    localparam int DW   = AXES * SAMPLE_WIDTH;

    // Configuration registers. Coefficients are signed with COEF_FRAC_BITS fraction bits;
    // b0 resets to one so that the filter passes samples straight through until programmed.
    logic                 r_mode;
    logic signed [CW-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_b0   <= CW'(1) << COEF_FRAC_BITS;
            r_b1   <= '0;
            r_b2   <= '0;
            r_a1   <= '0;
            r_a2   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tabq_pkg::CFG_FILTER_MODE: r_mode <= i_cfg_data[0];
                tabq_pkg::CFG_COEF_B0:     r_b0   <= i_cfg_data;
                tabq_pkg::CFG_COEF_B1:     r_b1   <= i_cfg_data;
                tabq_pkg::CFG_COEF_B2:     r_b2   <= i_cfg_data;
                tabq_pkg::CFG_COEF_A1:     r_a1   <= i_cfg_data;
                tabq_pkg::CFG_COEF_A2:     r_a2   <= i_cfg_data;
                default: begin
                    // Writes to unmapped indexes are dropped.
                end
            endcase
        end
    end

    // A transaction enters whenever the output buffer has a free entry. The buffer holds
    // two results, so the input keeps flowing while one result waits downstream.
    logic w_accept;
    logic w_full;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    // One lane per axis. Each keeps its own history and shares the coefficient set.
    logic signed [SAMPLE_WIDTH-1:0] w_samp [AXES];
    logic signed [SAMPLE_WIDTH-1:0] w_res  [AXES];
    logic [DW-1:0]                  w_push_data;
    logic [DW-1:0]                  w_out_data;

    assign w_samp[0] = i_gyro_x;
    assign w_samp[1] = i_gyro_y;
    assign w_samp[2] = i_gyro_z;

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        tabq_lane #(
            .SAMPLE_WIDTH   (SAMPLE_WIDTH),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_accept  (w_accept),
            .i_mode    (r_mode),
            .i_coef_b0 (r_b0),
            .i_coef_b1 (r_b1),
            .i_coef_b2 (r_b2),
            .i_coef_a1 (r_a1),
            .i_coef_a2 (r_a2),
            .i_sample  (w_samp[g]),
            .o_result  (w_res[g])
        );
        assign w_push_data[g*SAMPLE_WIDTH +: SAMPLE_WIDTH] = w_res[g];
    end

    // The merging stage packs the three lane results into one buffered transaction.
    tabq_merge #(
        .DATA_WIDTH (DW)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_push_data),
        .i_stall (i_stall),
        .o_full  (w_full),
        .o_valid (o_valid),
        .o_data  (w_out_data)
    );

    assign o_filt_x = w_out_data[0*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    assign o_filt_y = w_out_data[1*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    assign o_filt_z = w_out_data[2*SAMPLE_WIDTH +: SAMPLE_WIDTH];

    // Every accepted transaction must leave a result waiting in the next cycle.
    a_accept_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid
    ) else $error("accepted transaction produced no result");

    // An empty output buffer never holds back the input.
    a_empty_no_stall: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall
    ) else $error("input stalled while no result was pending");

    // In bypass, a transaction entering an empty buffer comes out unchanged.
    a_bypass_passes: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_mode && !o_valid) |=>
            (o_filt_x == $past(i_gyro_x)) && (o_filt_y == $past(i_gyro_y)) &&
            (o_filt_z == $past(i_gyro_z))
    ) else $error("bypass result differs from its input sample");

endmodule
